FILE: design/iaq_pkg.sv
`default_nettype none
package iaq_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int HUM_W      = 14;
   localparam int GAS_W      = 32;
   localparam int TEMP_W     = 15;
   localparam int WEIGHT_W   = 7;
   localparam int TBASE_W    = 14;
   localparam int SCORE_W    = 9;
   localparam int PPM_W      = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int GAS_PROD_W = GAS_W + WEIGHT_W;
   localparam int HPROD_W    = HUM_W + WEIGHT_W;
   localparam int GQ_W       = 3;

   localparam int TAB_W      = 37;
   localparam int TAB_DEPTH  = 501;
   localparam int TAB_FRAC   = 20;
   localparam int TAB_SPLIT  = 18;

   localparam logic [31:0]       EXP_STEP_Q32 = 32'd51850086;
   localparam logic [PPM_W-1:0]  CO2_MAX      = '1;

   localparam logic [HUM_W-1:0]    HUM_FULL       = 14'd10000;
   localparam logic [HUM_W-1:0]    HUM_BASE_MAX   = 14'd9999;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 7'd100;
   localparam logic [WEIGHT_W-1:0] PCT_FULL       = 7'd100;
   localparam logic [WEIGHT_W-1:0] GAS_SCORE_BASE = 7'd70;
   localparam logic [SCORE_W-1:0]  SCORE_MAX      = 9'd500;

   localparam logic [HUM_W-1:0]    HUM_BASE_RST  = 14'd4000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = 7'd25;
   localparam logic [GAS_W-1:0]    GAS_BASE_RST  = 32'd13478;
   localparam logic [TBASE_W-1:0]  TEMP_BASE_RST = 14'd2496;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUM_BASE   = 2'd0,
      CSR_HUM_WEIGHT = 2'd1,
      CSR_GAS_BASE   = 2'd2,
      CSR_TEMP_BASE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic            valid;
      logic            invalid;
      logic            neg_h;
      logic            gas_low;
      logic [GQ_W-1:0] gas_q;
      logic            hup;
      logic            tup;
   } iaq_side_type;

   typedef logic [TAB_W-1:0] exp_tab_type [0:TAB_DEPTH-1];

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] p;
      tab[0] = TAB_W'(64'd250 << TAB_FRAC);
      for (int s = 1; s < TAB_DEPTH; s++) begin
         p      = 64'(tab[s-1]);
         tab[s] = TAB_W'(p + ((p * 64'(EXP_STEP_Q32) + 64'h8000_0000) >> 32));
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

FILE: design/iaq_div_pipe.sv
`default_nettype none
module iaq_div_pipe import iaq_pkg::*; #(
   parameter int NW = 55,
   parameter int DW = 14
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [NW-1:0] numerator,
   input  wire logic [DW-1:0] denominator,
   output logic      [NW-1:0] quotient
);

   logic [NW-1:0] nq_ff  [0:NW-1];
   logic [DW-1:0] rem_ff [0:NW-1];
   logic [DW-1:0] den_ff [0:NW-1];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic [NW-1:0] nq_prev;
      logic [DW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [DW:0]   rem_sh;
      logic          ge;
      logic [NW-1:0] nq_in;
      logic [DW-1:0] rem_in;

      if (i == 0) begin : g_first
         assign nq_prev  = numerator;
         assign rem_prev = '0;
         assign den_prev = denominator;
      end else begin : g_next
         assign nq_prev  = nq_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      always_comb begin
         rem_sh = {rem_prev, nq_prev[NW-1]};
         ge     = rem_sh >= {1'b0, den_prev};
         rem_in = ge ? DW'(rem_sh - {1'b0, den_prev}) : DW'(rem_sh);
         nq_in  = {nq_prev[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            nq_ff[i]  <= nq_in;
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
         end
      end
   end

   assign quotient = nq_ff[NW-1];

endmodule
`default_nettype wire

FILE: design/iaq_co2_calc.sv
`default_nettype none
module iaq_co2_calc import iaq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire iaq_side_type                  side,
   input  wire logic [HPROD_W+FRACTION_BITS-1:0] hs_quo,
   input  wire logic [WEIGHT_W+FRACTION_BITS-1:0] gs_quo,
   input  wire logic [HUM_W+FRACTION_BITS-1:0] hr_quo,
   input  wire logic [HUM_W+FRACTION_BITS-1:0] tr_quo,
   output logic                               out_valid,
   output logic [SCORE_W-1:0]                 out_score,
   output logic [PPM_W-1:0]                   out_ppm,
   output logic                               out_saturated,
   output logic                               out_invalid
);

   localparam int HS_W   = HPROD_W + FRACTION_BITS;
   localparam int SUM_W  = HS_W + 2;
   localparam int FAC_W  = HUM_W + 1 + FRACTION_BITS;
   localparam int PHI_W  = TAB_W - TAB_SPLIT + FAC_W;
   localparam int PLO_W  = TAB_SPLIT + FAC_W;
   localparam int PROD_W = TAB_W + FAC_W;
   localparam int SHIFT  = TAB_FRAC + FRACTION_BITS;
   localparam int TOP_W  = PROD_W - SHIFT;
   localparam int PCT_W  = SUM_W - FRACTION_BITS;

   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic                inv1_ff, inv2_ff, inv3_ff;
   logic [SCORE_W-1:0]  score1_ff, score2_ff, score3_ff;
   logic [FAC_W-1:0]    fac1_ff, fac2_ff;
   logic [TAB_W-1:0]    tab2_ff;
   logic [PHI_W-1:0]    phi3_ff;
   logic [PLO_W-1:0]    plo3_ff;
   logic [SCORE_W-1:0]  score4_ff;
   logic [PPM_W-1:0]    ppm4_ff;
   logic                sat4_ff, inv4_ff;

   logic signed [SUM_W-1:0] gs_val, hs_val, sum;
   logic [PCT_W-1:0]        pct;
   logic [SCORE_W-1:0]      score1_in;
   logic [FAC_W-1:0]        fac1_in, one_fac;
   logic [PROD_W-1:0]       prod;
   logic [TOP_W-1:0]        top;
   logic [PPM_W-1:0]        ppm4_in;
   logic                    sat4_in;

   always_comb begin
      one_fac = FAC_W'(1) << FRACTION_BITS;
      if (side.gas_low) begin
         gs_val = SUM_W'(gs_quo);
      end else begin
         gs_val = SUM_W'({GAS_SCORE_BASE + WEIGHT_W'(side.gas_q), {FRACTION_BITS{1'b0}}});
      end
      hs_val = SUM_W'(hs_quo);
      sum    = side.neg_h ? gs_val - hs_val : gs_val + hs_val;
      pct    = PCT_W'(sum >>> FRACTION_BITS);
      if (sum < 0) begin
         score1_in = SCORE_MAX;
      end else if (pct >= PCT_W'(PCT_FULL)) begin
         score1_in = '0;
      end else begin
         score1_in = SCORE_W'(SCORE_W'(PCT_FULL - WEIGHT_W'(pct)) * SCORE_W'(5));
      end
      if (side.hup && side.tup) begin
         fac1_in = FAC_W'(hr_quo) + FAC_W'(tr_quo);
      end else if (side.hup) begin
         fac1_in = FAC_W'(hr_quo);
      end else if (side.tup) begin
         fac1_in = one_fac + FAC_W'(tr_quo);
      end else begin
         fac1_in = one_fac;
      end
   end

   always_comb begin
      prod    = (PROD_W'(phi3_ff) << TAB_SPLIT) + PROD_W'(plo3_ff);
      top     = TOP_W'(prod >> SHIFT);
      sat4_in = top > TOP_W'(CO2_MAX);
      ppm4_in = sat4_in ? CO2_MAX : PPM_W'(top);
      if (inv3_ff) begin
         sat4_in = 1'b0;
         ppm4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= side.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         inv1_ff   <= side.invalid;
         score1_ff <= score1_in;
         fac1_ff   <= fac1_in;
         inv2_ff   <= inv1_ff;
         score2_ff <= score1_ff;
         fac2_ff   <= fac1_ff;
         tab2_ff   <= EXP_TAB[score1_ff];
         inv3_ff   <= inv2_ff;
         score3_ff <= score2_ff;
         phi3_ff   <= PHI_W'(tab2_ff[TAB_W-1:TAB_SPLIT]) * PHI_W'(fac2_ff);
         plo3_ff   <= PLO_W'(tab2_ff[TAB_SPLIT-1:0]) * PLO_W'(fac2_ff);
         inv4_ff   <= inv3_ff;
         score4_ff <= inv3_ff ? '0 : score3_ff;
         ppm4_ff   <= ppm4_in;
         sat4_ff   <= sat4_in;
      end
   end

   assign out_valid     = v4_ff;
   assign out_score     = score4_ff;
   assign out_ppm       = ppm4_ff;
   assign out_saturated = sat4_ff;
   assign out_invalid   = inv4_ff;

endmodule
`default_nettype wire

FILE: design/indoor_air_quality_eco2_estimator_unit.sv
`default_nettype none
// Estimates an air quality score and a CO2 level in ppm from one humidity, gas resistance and
// temperature sample, with no state kept between samples. One sample is accepted every cycle
// unless the result side stalls; the pipelined dividers are bit-serial (one quotient bit per
// stage) and are followed by the score, table, multiplier and saturation stages. A stall on the
// result side holds the whole pipeline. Baselines and weight are written through the csr port;
// the user must write them only while no transfer is in flight; the block does not enforce it.
module indoor_air_quality_eco2_estimator_unit import iaq_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [HUM_W-1:0]         req_humidity_reading,
   input  wire logic [GAS_W-1:0]         req_gas_resistance_ohm,
   input  wire logic signed [TEMP_W-1:0] req_temperature_reading,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [SCORE_W-1:0]            rsp_air_quality_score,
   output logic [PPM_W-1:0]              rsp_co2_estimate_ppm,
   output logic                          rsp_co2_saturated,
   output logic                          rsp_input_invalid
);

   localparam int NUM_W = GAS_PROD_W + FRACTION_BITS;
   localparam int HS_W  = HPROD_W + FRACTION_BITS;
   localparam int GS_W  = WEIGHT_W + FRACTION_BITS;
   localparam int R_W   = HUM_W + FRACTION_BITS;

   logic                 advance;

   logic [HUM_W-1:0]     hum_base_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [GAS_W-1:0]     gas_base_ff;
   logic [TBASE_W-1:0]   temp_base_ff;

   logic                     v1_ff;
   logic [HUM_W-1:0]         h1_ff;
   logic [GAS_W-1:0]         g1_ff;
   logic signed [TEMP_W-1:0] t1_ff;

   iaq_side_type         side2_in, side2_ff;
   logic [NUM_W-1:0]     num_hs_in, num_gs_in, num_hr_in, num_tr_in;
   logic [NUM_W-1:0]     num_hs_ff, num_gs_ff, num_hr_ff, num_tr_ff;
   logic [HUM_W-1:0]     den_hs_in, den_hs_ff, den_hr_ff;
   logic [GAS_W-1:0]     den_gs_ff;
   logic [TBASE_W-1:0]   den_tr_ff;

   iaq_side_type         side_ff [0:NUM_W-1];

   logic [NUM_W-1:0]     q_hs, q_gs, q_hr, q_tr;

   logic [HUM_W-1:0]     hb;
   logic [WEIGHT_W-1:0]  w;
   logic [GAS_W-1:0]     gb;
   logic [TBASE_W-1:0]   ta;
   logic [HUM_W-1:0]     mag_h;
   logic [HPROD_W-1:0]   hprod;
   logic [GAS_PROD_W-1:0] gprod;
   logic [GAS_W+2:0]     g5;
   logic [GAS_W+3:0]     gb_k [1:5];
   logic [TEMP_W-1:0]    t_diff;
   logic [GQ_W-1:0]      q_sum;

   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_base_ff  <= HUM_BASE_RST;
         weight_ff    <= WEIGHT_RST;
         gas_base_ff  <= GAS_BASE_RST;
         temp_base_ff <= TEMP_BASE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HUM_BASE:   hum_base_ff  <= csr_wdata[HUM_W-1:0];
            CSR_HUM_WEIGHT: weight_ff    <= csr_wdata[WEIGHT_W-1:0];
            CSR_GAS_BASE:   gas_base_ff  <= csr_wdata[GAS_W-1:0];
            CSR_TEMP_BASE:  temp_base_ff <= csr_wdata[TBASE_W-1:0];
            default:        hum_base_ff  <= hum_base_ff;
         endcase
      end
   end

   always_comb begin
      hb = hum_base_ff;
      if (hum_base_ff == '0) begin
         hb = HUM_W'(1);
      end else if (hum_base_ff > HUM_BASE_MAX) begin
         hb = HUM_BASE_MAX;
      end
      w  = (weight_ff > WEIGHT_MAX) ? WEIGHT_MAX : weight_ff;
      gb = (gas_base_ff == '0) ? GAS_W'(1) : gas_base_ff;
      ta = (temp_base_ff == '0) ? TBASE_W'(1) : temp_base_ff;

      side2_in.valid   = v1_ff;
      side2_in.invalid = (h1_ff == '0) || (g1_ff == '0) || (t1_ff == '0);
      side2_in.hup     = h1_ff > hb;
      side2_in.tup     = t1_ff > $signed({1'b0, ta});
      side2_in.neg_h   = side2_in.hup && (h1_ff > HUM_FULL);
      side2_in.gas_low = gb > g1_ff;

      if (side2_in.neg_h) begin
         mag_h = h1_ff - HUM_FULL;
      end else if (side2_in.hup) begin
         mag_h = HUM_FULL - h1_ff;
      end else begin
         mag_h = h1_ff;
      end
      den_hs_in = side2_in.hup ? HUM_FULL - hb : hb;
      hprod     = HPROD_W'(mag_h) * HPROD_W'(w);
      num_hs_in = NUM_W'({hprod, {FRACTION_BITS{1'b0}}});

      gprod     = GAS_PROD_W'(g1_ff) * GAS_PROD_W'(PCT_FULL - w);
      num_gs_in = {gprod, {FRACTION_BITS{1'b0}}};

      g5 = (GAS_W+3)'(g1_ff) * (GAS_W+3)'(5);
      q_sum = '0;
      for (int k = 1; k <= 5; k++) begin
         gb_k[k] = (GAS_W+4)'(gb) * (GAS_W+4)'(5 + k);
         if ({1'b0, g5} >= gb_k[k]) begin
            q_sum = q_sum + GQ_W'(1);
         end
      end
      side2_in.gas_q = q_sum;

      num_hr_in = NUM_W'({h1_ff, {FRACTION_BITS{1'b0}}});
      t_diff    = TEMP_W'(t1_ff) - {1'b0, ta};
      num_tr_in = side2_in.tup ? NUM_W'({t_diff[TEMP_W-2:0], {FRACTION_BITS{1'b0}}}) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         side2_ff.valid <= 1'b0;
      end else if (advance) begin
         v1_ff          <= req_valid;
         side2_ff       <= side2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         h1_ff            <= req_humidity_reading;
         g1_ff            <= req_gas_resistance_ohm;
         t1_ff            <= req_temperature_reading;
         num_hs_ff        <= num_hs_in;
         num_gs_ff        <= num_gs_in;
         num_hr_ff        <= num_hr_in;
         num_tr_ff        <= num_tr_in;
         den_hs_ff        <= den_hs_in;
         den_gs_ff        <= gb;
         den_hr_ff        <= hb;
         den_tr_ff        <= ta;
      end
   end

   for (genvar i = 0; i < NUM_W; i++) begin : g_side
      iaq_side_type prev;
      if (i == 0) begin : g_first
         assign prev = side2_ff;
      end else begin : g_next
         assign prev = side_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else if (advance) begin
            side_ff[i] <= prev;
         end
      end
   end

   iaq_div_pipe #(.NW(NUM_W), .DW(HUM_W)) u_div_hs (
      .clock(clock), .enable(advance), .numerator(num_hs_ff),
      .denominator(den_hs_ff), .quotient(q_hs)
   );

   iaq_div_pipe #(.NW(NUM_W), .DW(GAS_W)) u_div_gs (
      .clock(clock), .enable(advance), .numerator(num_gs_ff),
      .denominator(den_gs_ff), .quotient(q_gs)
   );

   iaq_div_pipe #(.NW(NUM_W), .DW(HUM_W)) u_div_hr (
      .clock(clock), .enable(advance), .numerator(num_hr_ff),
      .denominator(den_hr_ff), .quotient(q_hr)
   );

   iaq_div_pipe #(.NW(NUM_W), .DW(TBASE_W)) u_div_tr (
      .clock(clock), .enable(advance), .numerator(num_tr_ff),
      .denominator(den_tr_ff), .quotient(q_tr)
   );

   iaq_co2_calc #(.FRACTION_BITS(FRACTION_BITS)) u_co2 (
      .clock(clock),
      .reset(reset),
      .enable(advance),
      .side(side_ff[NUM_W-1]),
      .hs_quo(q_hs[HS_W-1:0]),
      .gs_quo(q_gs[GS_W-1:0]),
      .hr_quo(q_hr[R_W-1:0]),
      .tr_quo(q_tr[R_W-1:0]),
      .out_valid(rsp_valid),
      .out_score(rsp_air_quality_score),
      .out_ppm(rsp_co2_estimate_ppm),
      .out_saturated(rsp_co2_saturated),
      .out_invalid(rsp_input_invalid)
   );

   assign advance = !rsp_valid || rsp_ready;

endmodule
`default_nettype wire

FILE: tb/tb_indoor_air_quality_eco2_estimator_unit.sv
`default_nettype none
module tb_indoor_air_quality_eco2_estimator_unit;
   import iaq_pkg::*;

   localparam int FRAC       = FRACTION_BITS_DEF;
   localparam int LATENCY    = FRAC + 45;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [PPM_W-1:0]   ppm;
      logic               saturated;
      logic               invalid;
   } air_estimate_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   logic                     req_valid;
   logic                     req_ready;
   logic [HUM_W-1:0]         req_humidity_reading;
   logic [GAS_W-1:0]         req_gas_resistance_ohm;
   logic signed [TEMP_W-1:0] req_temperature_reading;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [SCORE_W-1:0]       rsp_air_quality_score;
   logic [PPM_W-1:0]         rsp_co2_estimate_ppm;
   logic                     rsp_co2_saturated;
   logic                     rsp_input_invalid;

   indoor_air_quality_eco2_estimator_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_we                  (csr_we),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_humidity_reading    (req_humidity_reading),
      .req_gas_resistance_ohm  (req_gas_resistance_ohm),
      .req_temperature_reading (req_temperature_reading),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_air_quality_score   (rsp_air_quality_score),
      .rsp_co2_estimate_ppm    (rsp_co2_estimate_ppm),
      .rsp_co2_saturated       (rsp_co2_saturated),
      .rsp_input_invalid       (rsp_input_invalid)
   );

   logic [HUM_W-1:0]    hum_base;
   logic [WEIGHT_W-1:0] hum_weight;
   logic [GAS_W-1:0]    gas_base;
   logic [TBASE_W-1:0]  temp_base;

   logic [TAB_W-1:0]  ppm_curve [0:TAB_DEPTH-1];
   air_estimate_type  pending_estimates [$];
   int                error_count;
   int                readings_sent;
   int                estimates_checked;
   int                invalid_seen;
   int                saturated_seen;
   int                idle_cycles;
   int                burst_left;
   int                stall_mode;
   int                stall_timer;
   logic [15:0]       stall_pattern;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic void build_ppm_curve();
      longint unsigned step;
      ppm_curve[0] = TAB_W'(64'd250 << 20);
      for (int s = 1; s < TAB_DEPTH; s++) begin
         step         = (64'(ppm_curve[s-1]) * 64'd51850086 + 64'h8000_0000) >> 32;
         ppm_curve[s] = TAB_W'(64'(ppm_curve[s-1]) + step);
      end
   endfunction

   function automatic air_estimate_type estimate_air(logic [HUM_W-1:0] h, logic [GAS_W-1:0] g,
                                                     logic signed [TEMP_W-1:0] t);
      air_estimate_type res;
      longint           hb, w, gb, ta, hs, gs, pct, score, q, hv, gv, tv;
      longint unsigned  hum_ratio, temp_ratio, factor;
      logic [127:0]     product;
      res = '0;
      if (h == 0 || g == 0 || t == 0) begin
         res.invalid = 1'b1;
         return res;
      end
      hv = longint'(h);
      gv = longint'(g);
      tv = longint'(t);
      hb = longint'(hum_base);
      if (hb < 1) hb = 1;
      if (hb > 9999) hb = 9999;
      w  = (hum_weight > 100) ? 100 : longint'(hum_weight);
      gb = (gas_base == 0) ? 1 : longint'(gas_base);
      ta = (temp_base == 0) ? 1 : longint'(temp_base);
      if (hv > hb) hs = ((10000 - hv) * w * (64'sd1 << FRAC)) / (10000 - hb);
      else hs = (hv * w * (64'sd1 << FRAC)) / hb;
      if (gb > gv) begin
         gs = (gv * (100 - w) * (64'sd1 << FRAC)) / gb;
      end else begin
         q = (5 * (gv - gb)) / gb;
         if (q > 5) q = 5;
         gs = (70 + q) * (64'sd1 << FRAC);
      end
      pct   = (hs + gs) / (64'sd1 << FRAC);
      score = (100 - pct) * 5;
      if (score < 0) score = 0;
      if (score > 500) score = 500;
      hum_ratio  = (64'(hv) << FRAC) / 64'(hb);
      temp_ratio = 0;
      if (tv > ta) temp_ratio = (64'(tv - ta) << FRAC) / 64'(ta);
      if (hv > hb) factor = (tv > ta) ? hum_ratio + temp_ratio : hum_ratio;
      else factor = (64'd1 << FRAC) + temp_ratio;
      product = (128'(ppm_curve[score]) * 128'(factor)) >> (20 + FRAC);
      res.score = SCORE_W'(score);
      if (product > 128'(CO2_MAX)) begin
         res.ppm       = CO2_MAX;
         res.saturated = 1'b1;
      end else begin
         res.ppm = PPM_W'(product);
      end
      return res;
   endfunction

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_HUM_BASE:   hum_base   = data[HUM_W-1:0];
         CSR_HUM_WEIGHT: hum_weight = data[WEIGHT_W-1:0];
         CSR_GAS_BASE:   gas_base   = data[GAS_W-1:0];
         CSR_TEMP_BASE:  temp_base  = data[TBASE_W-1:0];
         default:        hum_base   = hum_base;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(logic [HUM_W-1:0] hb, logic [WEIGHT_W-1:0] w,
                            logic [GAS_W-1:0] gb, logic [TBASE_W-1:0] ta);
      write_register(CSR_HUM_BASE, 32'(hb));
      write_register(CSR_HUM_WEIGHT, 32'(w));
      write_register(CSR_GAS_BASE, gb);
      write_register(CSR_TEMP_BASE, 32'(ta));
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_reading(logic [HUM_W-1:0] h, logic [GAS_W-1:0] g,
                               logic signed [TEMP_W-1:0] t);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         req_valid  = 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_valid               = 1'b1;
      req_humidity_reading    = h;
      req_gas_resistance_ohm  = g;
      req_temperature_reading = t;
      do @(posedge clock); while (!req_ready);
      pending_estimates.push_back(estimate_air(h, g, t));
      readings_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_until_drained();
      req_valid = 1'b0;
      while (pending_estimates.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic [HUM_W-1:0] pick_humidity();
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2:    return HUM_W'($urandom_range(10001, 16383));
         3:       return HUM_W'($urandom);
         default: return HUM_W'($urandom_range(1, 10000));
      endcase
   endfunction

   function automatic logic [GAS_W-1:0] pick_gas();
      longint gb, v;
      gb = (gas_base == 0) ? 1 : longint'(gas_base);
      case ($urandom_range(0, 19))
         0:          v = 0;
         1, 2, 3:    v = $urandom;
         4, 5, 6, 7: v = gb + longint'($urandom_range(0, 32'(gb / 4 + 2)));
         8, 9:       v = gb + longint'($urandom_range(0, 32'(gb * 2 < 64'hFFFF_FFFF ?
                                                                 gb * 2 : 64'hFFFF_FFFF)));
         default:    v = $urandom_range(1, 32'(gb));
      endcase
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      return GAS_W'(v);
   endfunction

   function automatic logic signed [TEMP_W-1:0] pick_temperature();
      case ($urandom_range(0, 19))
         0:       return '0;
         1, 2:    return TEMP_W'($urandom);
         default: return TEMP_W'(int'($urandom_range(0, 12500)) - 4000);
      endcase
   endfunction

   task automatic test_directed_readings();
      send_reading(14'd4000, 32'd13478, 15'sd2496);
      send_reading(14'd0, 32'd13478, 15'sd2496);
      send_reading(14'd4000, 32'd0, 15'sd2496);
      send_reading(14'd4000, 32'd13478, 15'sd0);
      send_reading(14'd1, 32'd1, 15'sd1);
      send_reading(14'd10000, 32'hFFFF_FFFF, 15'sd8500);
      send_reading(14'h3FFF, 32'hFFFF_FFFF, 15'sh3FFF);
      send_reading(14'd16383, 32'd1, -15'sd16384);
      send_reading(14'd9999, 32'd13477, -15'sd4000);
      send_reading(14'd4001, 32'd13478, 15'sd2497);
      send_reading(14'd3999, 32'd80868, 15'sd2495);
      send_reading(14'd10000, 32'd94346, 15'sd16383);
      send_reading(14'd2000, 32'd6739, 15'sd100);
      send_reading(14'd12000, 32'd20000, 15'sd5000);
      send_reading(14'd10000, 32'd1, 15'sd8500);
      send_reading(14'd1, 32'hFFFF_FFFF, -15'sd1);
      wait_until_drained();
   endtask

   task automatic test_baseline_extremes();
      configure(14'd0, 7'd127, 32'd0, 14'd0);
      send_reading(14'd10000, 32'd1, 15'sd8500);
      send_reading(14'd1, 32'hFFFF_FFFF, 15'sd1);
      send_reading(14'h3FFF, 32'd2, 15'sh3FFF);
      wait_until_drained();
      configure(14'h3FFF, 7'd0, 32'hFFFF_FFFF, 14'h3FFF);
      send_reading(14'd9999, 32'hFFFF_FFFE, 15'sh3FFF);
      send_reading(14'd10000, 32'hFFFF_FFFF, 15'sd8500);
      send_reading(14'h3FFF, 32'd1, -15'sd1);
      wait_until_drained();
   endtask

   task automatic test_random_readings(int count);
      repeat (count) send_reading(pick_humidity(), pick_gas(), pick_temperature());
      wait_until_drained();
   endtask

   task automatic test_random_settings();
      test_random_readings(230);
      configure(14'd1, 7'd100, 32'd1, 14'd1);
      test_random_readings(230);
      configure(14'd9999, 7'd0, 32'hFFFF_FFFF, 14'd8500);
      test_random_readings(230);
      configure(14'h3FFF, 7'h7F, 32'd0, 14'h3FFF);
      test_random_readings(200);
      for (int k = 0; k < 4; k++) begin
         configure(HUM_W'($urandom_range(0, 16383)), WEIGHT_W'($urandom_range(0, 127)),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 200000),
                   TBASE_W'($urandom_range(0, 16383)));
         test_random_readings(200);
      end
      configure(HUM_BASE_RST, WEIGHT_RST, GAS_BASE_RST, TEMP_BASE_RST);
      test_random_readings(80);
   endtask

   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_timer <= $urandom_range(50, 400);
      end else begin
         stall_timer <= stall_timer - 1;
      end
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 9) > 2);
         2:       rsp_ready <= stall_pattern[15];
         default: rsp_ready <= ($urandom_range(0, 9) > 7);
      endcase
   end

   always @(posedge clock) begin
      air_estimate_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_estimates.size() == 0) begin
            $display("%0t: result transfer with no reading outstanding", $time);
            error_count++;
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_air_quality_score !== want.score) begin
               $display("%0t: air_quality_score expected %0d actual %0d",
                        $time, want.score, rsp_air_quality_score);
               error_count++;
            end
            if (rsp_co2_estimate_ppm !== want.ppm) begin
               $display("%0t: co2_estimate_ppm expected %0d actual %0d",
                        $time, want.ppm, rsp_co2_estimate_ppm);
               error_count++;
            end
            if (rsp_co2_saturated !== want.saturated) begin
               $display("%0t: co2_saturated expected %0b actual %0b",
                        $time, want.saturated, rsp_co2_saturated);
               error_count++;
            end
            if (rsp_input_invalid !== want.invalid) begin
               $display("%0t: input_invalid expected %0b actual %0b",
                        $time, want.invalid, rsp_input_invalid);
               error_count++;
            end
            estimates_checked++;
            if (want.invalid) invalid_seen++;
            if (want.saturated) saturated_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = CSR_HUM_BASE;
      csr_wdata               = '0;
      req_valid               = 1'b0;
      req_humidity_reading    = '0;
      req_gas_resistance_ohm  = '0;
      req_temperature_reading = '0;
      rsp_ready               = 1'b0;
      stall_mode              = 0;
      stall_timer             = 0;
      stall_pattern           = 16'b1101_0011_1110_0101;
      error_count             = 0;
      readings_sent           = 0;
      estimates_checked       = 0;
      invalid_seen            = 0;
      saturated_seen          = 0;
      idle_cycles             = 0;
      burst_left              = 0;
      hum_base                = HUM_BASE_RST;
      hum_weight              = WEIGHT_RST;
      gas_base                = GAS_BASE_RST;
      temp_base               = TEMP_BASE_RST;
      build_ppm_curve();
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed_readings();
      test_baseline_extremes();
      test_random_settings();
      $display("Sent %0d readings and checked %0d estimates, %0d invalid and %0d saturated,",
               readings_sent, estimates_checked, invalid_seen, saturated_seen);
      $display("across reset, extreme and random baselines with random stalls on both sides.");
      if (error_count == 0 && pending_estimates.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
